### hw/rtl/multi_ant_grid_automaton_core_assert.svh
// Assertion macros for the RTL of the ant grid core, used by its top file.
// Both macros expect clk and rst in the scope where they are used.
`ifndef MULTI_ANT_GRID_AUTOMATON_CORE_ASSERT_SVH
`define MULTI_ANT_GRID_AUTOMATON_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MAGAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MAGAC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define MAGAC_ASSERT(lbl, prop, msg)
`define MAGAC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

### hw/rtl/magac_pkg.sv
package magac_pkg;

  localparam int ANTS = 8;
  localparam int ROWS = 16;
  localparam int COLS = 16;

  localparam int START_DELAY = 3;
  localparam int COLOR_LIMIT = 9;

  localparam int ANT_W  = (ANTS > 1) ? $clog2(ANTS) : 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELLS  = ROWS * COLS;
  localparam int GRID_AW = $clog2(CELLS);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_PLACE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_PAINT,
    ST_RD1,
    ST_TURN
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       heading;
  } ant_t;

  // Result of the shared step unit for the ant under work.
  typedef struct packed {
    logic [3:0] paint_color;
    logic [3:0] color_next;
    ant_t       moved;
    logic [1:0] turned;
  } step_t;

  // Start coordinates are 4 bits wide; these fold them onto the grid.
  function automatic logic [ROW_W-1:0] row_wrap(input logic [3:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = ROW_W'(i % ROWS);
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] col_wrap(input logic [3:0] v);
    logic [COL_W-1:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) c = COL_W'(i % COLS);
    end
    return c;
  endfunction

  function automatic logic [GRID_AW-1:0] cell_addr(input ant_t a);
    return GRID_AW'(a.row) * GRID_AW'(COLS) + GRID_AW'(a.col);
  endfunction

endpackage

### hw/rtl/magac_if.sv
interface magac_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] ant_index;
  logic [3:0] start_row;
  logic [3:0] start_col;
  logic [1:0] start_heading;

  modport source(output valid, req_type, ant_index, start_row, start_col, start_heading,
                 input ready);
  modport sink(input valid, req_type, ant_index, start_row, start_col, start_heading,
               output ready);
endinterface

interface magac_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_row;
  logic [3:0] pixel_col;
  logic [3:0] pixel_color;
  logic       last;

  modport source(output valid, pixel_row, pixel_col, pixel_color, last, input ready);
  modport sink(input valid, pixel_row, pixel_col, pixel_color, last, output ready);
endinterface

### hw/rtl/multi_ant_grid_automaton_core.sv
// Langton ants on a toroidal color grid. A clear, a place, an unknown request and a tick
// that only spends the start delay give no pixel writes. A running tick is accepted in
// idle and then visits the ants in order, each in four steps (read the cell, paint it and
// step, read the new cell, turn); the paint step waits while a finished pixel write is not
// yet taken, and the pace is set by the single grid memory that the two reads and the write
// share. The input is not ready until the tick has finished. A clear takes effect at once
// through per-cell written flags, so there is no clearing pass.
`include "multi_ant_grid_automaton_core_assert.svh"
module multi_ant_grid_automaton_core (
  input logic         clk,
  input logic         rst,
  magac_req_if.sink   req,
  magac_pix_if.source pix
);
  import magac_pkg::*;

  state_t             state;
  state_t             state_next;
  ant_t               ants [ANTS];
  ant_t               cur;
  logic [ANT_W-1:0]   ant_cnt;
  logic [3:0]         next_color;
  logic [1:0]         start_delay;
  step_t              step;
  logic [3:0]         cell_color;

  logic               req_fire;
  logic               paint_go;
  logic               last_ant;
  logic               req_ready;
  logic               grid_rd;
  logic               grid_wr;
  logic               grid_clear;

  logic               out_valid;
  logic [3:0]         out_row;
  logic [3:0]         out_col;
  logic [3:0]         out_color;
  logic               out_last;

  assign cur      = ants[ant_cnt];
  assign req_fire = req.valid && req_ready;
  assign paint_go = !out_valid || pix.ready;
  assign last_ant = (ant_cnt == ANT_W'(ANTS - 1));

  magac_grid u_grid (
    .clk       (clk),
    .rst       (rst),
    .clear     (grid_clear),
    .rd_en     (grid_rd),
    .rd_addr   (cell_addr(cur)),
    .wr_en     (grid_wr),
    .wr_addr   (cell_addr(cur)),
    .wr_data   (step.paint_color),
    .cell_color(cell_color)
  );

  magac_step_unit u_step (
    .cur       (cur),
    .cell_color(cell_color),
    .color     (next_color),
    .res       (step)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && req.req_type == REQ_TICK && start_delay == 2'd0) begin
          state_next = ST_RD0;
        end
      end
      ST_RD0:   state_next = ST_PAINT;
      ST_PAINT: state_next = paint_go ? ST_RD1 : ST_PAINT;
      ST_RD1:   state_next = ST_TURN;
      ST_TURN:  state_next = last_ant ? ST_IDLE : ST_RD0;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    grid_rd    = 1'b0;
    grid_wr    = 1'b0;
    grid_clear = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        grid_clear = req.valid && req.req_type == REQ_CLEAR;
      end
      ST_RD0:   grid_rd = 1'b1;
      ST_PAINT: grid_wr = paint_go;
      ST_RD1:   grid_rd = 1'b1;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANTS; i++) ants[i] <= '0;
      ant_cnt     <= '0;
      next_color  <= 4'd1;
      start_delay <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            case (req.req_type)
              REQ_CLEAR: start_delay <= 2'(START_DELAY);
              REQ_PLACE: begin
                if (int'(req.ant_index) < ANTS) begin
                  ants[ANT_W'(req.ant_index)] <= '{row: row_wrap(req.start_row),
                                                   col: col_wrap(req.start_col),
                                                   heading: req.start_heading};
                end
              end
              REQ_TICK: begin
                if (start_delay != 2'd0) start_delay <= start_delay - 2'd1;
                ant_cnt <= '0;
              end
              default: start_delay <= start_delay;
            endcase
          end
        end
        ST_PAINT: begin
          if (paint_go) begin
            ants[ant_cnt] <= step.moved;
            next_color    <= step.color_next;
          end
        end
        ST_TURN: begin
          ants[ant_cnt].heading <= step.turned;
          if (!last_ant) ant_cnt <= ant_cnt + ANT_W'(1);
        end
        default: begin
          ant_cnt <= ant_cnt;
        end
      endcase
    end
  end

  // Output register: one pixel write waits here while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PAINT && paint_go) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PAINT && paint_go) begin
      out_row   <= 4'(cur.row);
      out_col   <= 4'(cur.col);
      out_color <= step.paint_color;
      out_last  <= last_ant;
    end
  end

  assign req.ready       = req_ready;
  assign pix.valid       = out_valid;
  assign pix.pixel_row   = out_row;
  assign pix.pixel_col   = out_col;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

  `MAGAC_ASSERT(a_color_range, next_color != 4'd0 && next_color < 4'(COLOR_LIMIT), "paint color out of range")
  `MAGAC_ASSERT(a_delay_range, start_delay <= 2'(START_DELAY), "start delay above its armed value")
  `MAGAC_ASSERT_NEXT(a_tick_starts, req_fire && req.req_type == REQ_TICK && start_delay == 2'd0, state == ST_RD0 && ant_cnt == '0, "running tick did not start at the first ant")
  `MAGAC_ASSERT_NEXT(a_paint_slot, state == ST_PAINT && paint_go, pix.valid && state == ST_RD1, "pixel write not presented after paint")

endmodule

### hw/rtl/magac_ram.sv
module magac_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/magac_grid.sv
module magac_grid (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           rd_en,
  input  logic [magac_pkg::GRID_AW-1:0]  rd_addr,
  input  logic                           wr_en,
  input  logic [magac_pkg::GRID_AW-1:0]  wr_addr,
  input  logic [3:0]                     wr_data,
  output logic [3:0]                     cell_color
);
  import magac_pkg::*;

  logic [CELLS-1:0] written;
  logic             rd_written;
  logic [3:0]       ram_data;

  magac_ram #(
    .WIDTH(4),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_data)
  );

  // One flag per cell lets a clear blank the whole grid at once.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_written <= 1'b0;
    end else if (rd_en) begin
      rd_written <= written[rd_addr];
    end
  end

  assign cell_color = rd_written ? ram_data : 4'd0;

endmodule

### hw/rtl/magac_step_unit.sv
module magac_step_unit (
  input  magac_pkg::ant_t  cur,
  input  logic [3:0]       cell_color,
  input  logic [3:0]       color,
  output magac_pkg::step_t res
);
  import magac_pkg::*;

  logic black;

  assign black = (cell_color == 4'd0);

  always_comb begin
    res = '0;
    res.paint_color = black ? color : 4'd0;
    if (black) begin
      res.color_next = (color == 4'(COLOR_LIMIT - 1)) ? 4'd1 : color + 4'd1;
    end else begin
      res.color_next = color;
    end

    res.moved = cur;
    case (cur.heading)
      HEAD_UP: begin
        res.moved.row = (cur.row == '0) ? ROW_W'(ROWS - 1) : cur.row - ROW_W'(1);
      end
      HEAD_RIGHT: begin
        res.moved.col = (cur.col == COL_W'(COLS - 1)) ? '0 : cur.col + COL_W'(1);
      end
      HEAD_DOWN: begin
        res.moved.row = (cur.row == ROW_W'(ROWS - 1)) ? '0 : cur.row + ROW_W'(1);
      end
      default: begin
        res.moved.col = (cur.col == '0) ? COL_W'(COLS - 1) : cur.col - COL_W'(1);
      end
    endcase

    // Turn right on a black cell, left otherwise.
    res.turned = black ? cur.heading + 2'd1 : cur.heading + 2'd3;
  end

endmodule
